// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the history checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define HUR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define HUR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/hur_pkg.sv
// ---------------------------------------------------------------------------
// hur_pkg
// shared types and constants of the bounded undo/redo history
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hur_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int S_DATA_W = 64;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 80;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [1:0] KIND_VIS  = 2'd0;
    localparam logic [1:0] KIND_SMP  = 2'd1;
    localparam logic [1:0] KIND_UNDO = 2'd2;
    localparam logic [1:0] KIND_REDO = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_UNDO = 2'd1;
    localparam logic [1:0] ST_NO_REDO = 2'd2;
    localparam logic [1:0] ST_BAD_ARG = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] vis_layer;
        logic [15:0] pix_col;
        logic [15:0] pix_row;
        logic [7:0]  new_value;
        logic [7:0]  old_value;
    } t_item;

    // one history record; addr holds the layer or the column
    typedef struct packed {
        logic        is_sample;
        logic [15:0] addr;
        logic [15:0] row;
        logic [7:0]  new_val;
        logic [7:0]  old_val;
    } t_entry;

    // what the first stage hands to the result stage
    typedef struct packed {
        logic [1:0]       status;
        logic             wr;
        logic             use_new;
        logic [CNT_W-1:0] position;
        logic [CNT_W-1:0] held;
    } t_s1;

endpackage

// File: src/hur_ram.sv
// ---------------------------------------------------------------------------
// hur_ram
// history record store, one write and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hur_ram
    import hur_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/hur_ctrl.sv
// ---------------------------------------------------------------------------
// hur_ctrl
// position, count and ring base update; issues the record store access
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hur_ctrl
    import hur_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_item            i_item,
    input  logic             i_out_free,
    output logic             o_s1_adv,
    output t_s1              o_s1,
    output logic             o_we,
    output logic             o_re,
    output logic [IDX_W-1:0] o_waddr,
    output logic [IDX_W-1:0] o_raddr,
    output t_entry           o_wdata
);

    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_base, n_base;
    logic             r_s1_valid;
    t_s1              r_s1, n_s1;

    logic             accept;
    logic             s1_adv;
    logic             we, re;
    logic [CNT_W-1:0] pos_dec;
    logic [IDX_W-1:0] idx;
    logic [IDX_W:0]   sum;
    logic [IDX_W-1:0] phys;

    assign s1_adv  = r_s1_valid && i_out_free;
    assign o_ready = !r_s1_valid || i_out_free;
    assign accept  = i_valid && o_ready;
    assign pos_dec = r_pos - CNT_W'(1);

    // logical slot to ring slot
    always_comb begin
        sum  = {1'b0, r_base} + {1'b0, idx};
        phys = (sum >= (IDX_W+1)'(CAPACITY)) ? IDX_W'(sum - (IDX_W+1)'(CAPACITY))
                                             : sum[IDX_W-1:0];
    end

    always_comb begin
        n_pos          = r_pos;
        n_cnt          = r_cnt;
        n_base         = r_base;
        we             = 1'b0;
        re             = 1'b0;
        idx            = r_pos[IDX_W-1:0];
        n_s1.status    = ST_OK;
        n_s1.wr        = 1'b0;
        n_s1.use_new   = 1'b0;
        case (i_item.kind)
            KIND_VIS, KIND_SMP: begin
                if (i_item.kind == KIND_VIS && i_item.vis_layer == 16'd0) begin
                    n_s1.status = ST_BAD_ARG;
                end else begin
                    // redo tail dropped; when full the oldest slot is reused
                    we = 1'b1;
                    if (r_pos == CAP_CNT) begin
                        n_cnt  = CAP_CNT;
                        n_base = (r_base == IDX_W'(CAPACITY - 1)) ? '0
                                                                  : r_base + IDX_W'(1);
                    end else begin
                        n_cnt = r_pos + CNT_W'(1);
                    end
                    n_pos = n_cnt;
                end
            end
            KIND_UNDO: begin
                if (r_pos == '0) begin
                    n_s1.status = ST_NO_UNDO;
                end else begin
                    re       = 1'b1;
                    idx      = pos_dec[IDX_W-1:0];
                    n_pos    = pos_dec;
                    n_s1.wr  = 1'b1;
                end
            end
            default: begin
                if (r_pos >= r_cnt) begin
                    n_s1.status = ST_NO_REDO;
                end else begin
                    re           = 1'b1;
                    n_pos        = r_pos + CNT_W'(1);
                    n_s1.wr      = 1'b1;
                    n_s1.use_new = 1'b1;
                end
            end
        endcase
        n_s1.position = n_pos;
        n_s1.held     = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_cnt      <= '0;
            r_base     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos  <= n_pos;
                r_cnt  <= n_cnt;
                r_base <= n_base;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_we    = accept && we;
    assign o_re    = accept && re;
    assign o_waddr = phys;
    assign o_raddr = phys;
    assign o_s1    = r_s1;
    assign o_s1_adv = s1_adv;

    always_comb begin
        o_wdata.is_sample = (i_item.kind == KIND_SMP);
        o_wdata.addr      = (i_item.kind == KIND_SMP) ? i_item.pix_col : i_item.vis_layer;
        o_wdata.row       = (i_item.kind == KIND_SMP) ? i_item.pix_row : 16'd0;
        o_wdata.new_val   = (i_item.kind == KIND_SMP) ? i_item.new_value
                                                      : {7'd0, |i_item.new_value};
        o_wdata.old_val   = i_item.old_value;
    end

endmodule

// File: src/hur_out.sv
// ---------------------------------------------------------------------------
// hur_out
// result register: builds the document write from the record read back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hur_out
    import hur_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_s1                 i_s1,
    input  t_entry              i_rdata,
    input  logic                i_m_tready,
    output logic                o_out_free,
    output logic                o_m_tvalid,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tuser
);

    logic                r_valid;
    logic [M_DATA_W-1:0] r_data, n_data;
    logic                r_user, n_user;

    logic [15:0] w_layer, w_x, w_y;
    logic [7:0]  w_value;

    always_comb begin
        w_layer = 16'd0;
        w_x     = 16'd0;
        w_y     = 16'd0;
        w_value = 8'd0;
        n_user  = 1'b0;
        if (i_s1.wr) begin
            n_user  = i_rdata.is_sample;
            w_value = i_s1.use_new ? i_rdata.new_val : i_rdata.old_val;
            if (i_rdata.is_sample) begin
                w_x = i_rdata.addr;
                w_y = i_rdata.row;
            end else begin
                w_layer = i_rdata.addr;
            end
        end
        n_data = {7'd0, i_s1.held, i_s1.position, w_value, w_y, w_x, w_layer,
                  i_s1.wr, i_s1.status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
            r_user <= n_user;
        end
    end

    assign o_out_free = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;

endmodule

// File: src/bounded_undo_redo_history.sv
// ---------------------------------------------------------------------------
// bounded_undo_redo_history
// bounded edit history with position pointer, undo and redo
// ---------------------------------------------------------------------------
// usage
//   slave channel carries one command item per handshake: tuser holds the
//   kind (record visibility, record sample, undo, redo), tdata the record.
//   master channel returns exactly one result item per command: status,
//   the document write to perform (if any), position and held count.
//   records sit in a 64-slot ring; a full history reuses the oldest slot.
//   the command is registered in the first stage when accepted; the result
//   register loads from that stage when free, and o_m_tvalid then rises.
//   throughput: one item per cycle unless the receiver stalls; at most one
//   record store access per item (write for a record, read for undo/redo).
//   reset clears position, count and ring base; stored records are not
//   cleared and are only ever read below the held count.
//   when the receiver stalls, the result register holds and one more
//   command may sit in the first stage; after that o_s_tready drops until
//   the result is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_undo_redo_history
    import hur_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // vis_layer[15:0], pix_col[31:16], pix_row[47:32], new_value[55:48],
    // old_value[63:56]
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // kind[1:0]
    input  logic [S_USER_W-1:0] i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // status[1:0], write_valid[2], write_layer[18:3], write_x[34:19],
    // write_y[50:35], write_value[58:51], position[65:59], held[72:66],
    // zero fill[79:73]
    output logic [M_DATA_W-1:0] o_m_tdata,
    // write_kind[0]
    output logic                o_m_tuser
);

    t_item            item;
    t_s1              s1;
    t_entry           wdata, rdata;
    logic             s1_adv, out_free;
    logic             we, re;
    logic [IDX_W-1:0] waddr, raddr;

    assign item.kind      = i_s_tuser;
    assign item.vis_layer = i_s_tdata[15:0];
    assign item.pix_col   = i_s_tdata[31:16];
    assign item.pix_row   = i_s_tdata[47:32];
    assign item.new_value = i_s_tdata[55:48];
    assign item.old_value = i_s_tdata[63:56];

    hur_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_item     (item),
        .i_out_free (out_free),
        .o_s1_adv   (s1_adv),
        .o_s1       (s1),
        .o_we       (we),
        .o_re       (re),
        .o_waddr    (waddr),
        .o_raddr    (raddr),
        .o_wdata    (wdata)
    );

    hur_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    hur_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_adv),
        .i_s1       (s1),
        .i_rdata    (rdata),
        .i_m_tready (i_m_tready),
        .o_out_free (out_free),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// File: src/hur_checker.sv
// ---------------------------------------------------------------------------
// hur_checker
// port-level checks on the history result stream
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hur_checker
    import hur_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic                o_m_tuser
);

    `HUR_ASSERT(a_hold_stalled, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")
    `HUR_ASSERT(a_held_bound, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[72:66] <= 7'(CAPACITY)) && (o_m_tdata[65:59] <= o_m_tdata[72:66]), "position or held out of range")
    `HUR_ASSERT(a_quiet_write, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[2] |-> (o_m_tdata[58:3] == '0) && !o_m_tuser, "write fields set without a write")
    `HUR_ASSERT(a_fail_no_write, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[1:0] != ST_OK) |-> !o_m_tdata[2], "failed command emits a write")
    `HUR_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind bounded_undo_redo_history hur_checker u_hur_checker (.*);

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// drives edit commands (records, undo, redo) into the bounded history over
// the stream ports, with random idle cycles on both sides and one long
// receiver hold-off. a shadow history in the bench computes each expected
// result item, and the monitor checks every received item field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import hur_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 19;
    localparam int QUIET_FROM   = 1500;
    localparam int QUIET_TO     = 2600;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [1:0]       status;
        logic             write_valid;
        logic             write_kind;
        logic [15:0]      write_layer;
        logic [15:0]      write_x;
        logic [15:0]      write_y;
        logic [7:0]       write_value;
        logic [CNT_W-1:0] position;
        logic [CNT_W-1:0] held;
    } t_outcome;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;
    logic [S_USER_W-1:0] i_s_tuser  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                o_m_tuser;

    t_item    command_q[$];
    t_outcome outcome_q[$];

    // shadow copy of the history
    t_entry      shadow_mem [CAPACITY];
    int unsigned shadow_pos = 0;
    int unsigned shadow_cnt = 0;

    int cycles       = 0;
    int errors       = 0;
    int results_seen = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    bounded_undo_redo_history u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_outcome apply_edit(t_item c);
        t_outcome o;
        t_entry   rec;
        t_entry   e;
        bit       do_append;
        int       i;
        o = '0;
        rec = '0;
        e = '0;
        do_append = 1'b0;
        case (c.kind)
            KIND_VIS: begin
                if (c.vis_layer == 16'd0) begin
                    o.status = ST_BAD_ARG;
                end else begin
                    rec.is_sample = 1'b0;
                    rec.addr      = c.vis_layer;
                    rec.new_val   = (c.new_value != 8'd0) ? 8'd1 : 8'd0;
                    rec.old_val   = c.old_value;
                    do_append     = 1'b1;
                end
            end
            KIND_SMP: begin
                rec.is_sample = 1'b1;
                rec.addr      = c.pix_col;
                rec.row       = c.pix_row;
                rec.new_val   = c.new_value;
                rec.old_val   = c.old_value;
                do_append     = 1'b1;
            end
            KIND_UNDO: begin
                if (shadow_pos == 0) begin
                    o.status = ST_NO_UNDO;
                end else begin
                    shadow_pos    = shadow_pos - 1;
                    e             = shadow_mem[shadow_pos];
                    o.write_valid = 1'b1;
                    o.write_value = e.old_val;
                end
            end
            default: begin
                if (shadow_pos >= shadow_cnt) begin
                    o.status = ST_NO_REDO;
                end else begin
                    e             = shadow_mem[shadow_pos];
                    o.write_valid = 1'b1;
                    o.write_value = e.new_val;
                    shadow_pos    = shadow_pos + 1;
                end
            end
        endcase
        if (o.write_valid) begin
            o.write_kind = e.is_sample;
            if (e.is_sample) begin
                o.write_x = e.addr;
                o.write_y = e.row;
            end else begin
                o.write_layer = e.addr;
            end
        end
        if (do_append) begin
            // a new record drops the redo tail, then the oldest entry if full
            if (shadow_pos < shadow_cnt) shadow_cnt = shadow_pos;
            if (shadow_cnt >= CAPACITY) begin
                for (i = 0; i < CAPACITY - 1; i++) shadow_mem[i] = shadow_mem[i + 1];
                shadow_cnt = CAPACITY - 1;
                if (shadow_pos > 0) shadow_pos = shadow_pos - 1;
            end
            shadow_mem[shadow_cnt] = rec;
            shadow_cnt = shadow_cnt + 1;
            shadow_pos = shadow_cnt;
        end
        o.position = CNT_W'(shadow_pos);
        o.held     = CNT_W'(shadow_cnt);
        return o;
    endfunction

    function automatic void add_cmd(logic [1:0] kind, logic [15:0] layer, logic [15:0] x,
                                    logic [15:0] y, logic [7:0] nv, logic [7:0] ov);
        t_item c;
        c.kind      = kind;
        c.vis_layer = layer;
        c.pix_col   = x;
        c.pix_row   = y;
        c.new_value = nv;
        c.old_value = ov;
        command_q.push_back(c);
    endfunction

    // random content; layers of visibility records are nonzero unless noisy
    function automatic void add_random_cmd(logic [1:0] kind, bit noisy);
        logic [15:0] layer;
        layer = 16'($urandom_range(65535));
        if (kind == KIND_VIS && !noisy && layer == 16'd0) layer = 16'd1;
        if (kind == KIND_VIS && noisy && $urandom_range(99) < 30) layer = 16'd0;
        add_cmd(kind, layer, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    function automatic logic [1:0] record_kind();
        return ($urandom_range(1) == 0) ? KIND_VIS : KIND_SMP;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                outcome_q.push_back(apply_edit(command_q.pop_front()));
            end
            if (i_s_tvalid && !o_s_tready) begin
                // keep the offered item until it is taken
            end else if (command_q.size() > 0 &&
                         ((cycles >= QUIET_FROM && cycles < QUIET_TO) ||
                          $urandom_range(99) >= IDLE_PCT)) begin
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= command_q[0].kind;
                i_s_tdata  <= {command_q[0].old_value, command_q[0].new_value,
                               command_q[0].pix_row, command_q[0].pix_col,
                               command_q[0].vis_layer};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver readiness
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (outcome_q.size() == 0) begin
                    $error("result item with no expectation waiting");
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", 32'(want.status), 32'(o_m_tdata[1:0]));
                    check_field("write_valid", 32'(want.write_valid), 32'(o_m_tdata[2]));
                    check_field("write_kind", 32'(want.write_kind), 32'(o_m_tuser));
                    check_field("write_layer", 32'(want.write_layer),
                                32'(o_m_tdata[18:3]));
                    check_field("write_x", 32'(want.write_x), 32'(o_m_tdata[34:19]));
                    check_field("write_y", 32'(want.write_y), 32'(o_m_tdata[50:35]));
                    check_field("write_value", 32'(want.write_value),
                                32'(o_m_tdata[58:51]));
                    check_field("position", 32'(want.position), 32'(o_m_tdata[65:59]));
                    check_field("held", 32'(want.held), 32'(o_m_tdata[72:66]));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                // long back-pressure so the block fills and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= (cycles >= QUIET_FROM && cycles < QUIET_TO) ||
                              ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int queued;
        int sel;
        int len;
        int j;

        // directed: empty undo/redo, invalid layer, field extremes
        add_cmd(KIND_UNDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        add_cmd(KIND_REDO, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff);
        add_cmd(KIND_VIS, 16'h0000, 16'h1234, 16'h5678, 8'h01, 8'h00);
        add_cmd(KIND_VIS, 16'hffff, 16'h0000, 16'h0000, 8'hff, 8'h00);
        add_cmd(KIND_VIS, 16'h0001, 16'hffff, 16'hffff, 8'h00, 8'hff);
        add_cmd(KIND_SMP, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        add_cmd(KIND_SMP, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff);
        add_cmd(KIND_UNDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        add_cmd(KIND_UNDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        add_cmd(KIND_REDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        add_cmd(KIND_REDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        add_cmd(KIND_REDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        add_cmd(KIND_UNDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        add_cmd(KIND_UNDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        // record after undo drops the redo tail
        add_cmd(KIND_SMP, 16'h0000, 16'h00aa, 16'h0055, 8'h5a, 8'ha5);
        add_cmd(KIND_REDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        for (j = 0; j < 5; j++) add_cmd(KIND_UNDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        add_cmd(KIND_REDO, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);

        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 12) begin
                // run past capacity so the oldest entries get dropped
                len = $urandom_range(60, 80);
                for (j = 0; j < len; j++) add_random_cmd(record_kind(), 1'b0);
            end else if (sel < 32) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
                for (j = 0; j < len; j++) add_random_cmd(KIND_UNDO, 1'b0);
            end else if (sel < 46) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
                for (j = 0; j < len; j++) add_random_cmd(KIND_REDO, 1'b0);
            end else if (sel < 56) begin
                len = $urandom_range(1, 8);
                for (j = 0; j < len; j++) add_random_cmd(2'($urandom_range(3)), 1'b1);
            end else begin
                len = $urandom_range(1, 10);
                for (j = 0; j < len; j++) begin
                    sel = $urandom_range(3);
                    add_random_cmd((sel < 2) ? record_kind() :
                                   ((sel == 2) ? KIND_UNDO : KIND_REDO), 1'b0);
                end
            end
            queued += len;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (command_q.size() > 0 || i_s_tvalid || outcome_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/hur_pkg.sv
src/hur_ram.sv
src/hur_ctrl.sv
src/hur_out.sv
src/bounded_undo_redo_history.sv
src/hur_checker.sv
verif/testbench.sv
